>>> hdl/pdss_pkg.sv
// ----------------------------------------------------------------------------
// pdss_pkg
// types, presets and control structs shared by the synth controller and datapath
// ----------------------------------------------------------------------------
package pdss_pkg;

  localparam int unsigned PHASE_W = 24;
  localparam int unsigned FREQ_W  = 22;
  localparam int unsigned VOL_W   = 16;
  localparam int unsigned SCALE_W = 18;

  localparam logic [FREQ_W-1:0] FREQ_FLOOR = 22'd2560;
  localparam logic [VOL_W-1:0]  VOL_FLOOR  = 16'd33;
  localparam logic [15:0]       LFSR_SEED  = 16'hACE1;
  localparam logic [15:0]       LFSR_TAPS  = 16'hB400;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd97392;

  localparam logic COMMAND_TRIGGER = 1'b0;
  localparam logic COMMAND_TICK    = 1'b1;

  localparam logic [1:0] PRESET_SHOOT   = 2'd0;
  localparam logic [1:0] PRESET_EXPLODE = 2'd1;
  localparam logic [1:0] PRESET_DASH    = 2'd2;
  localparam logic [1:0] PRESET_BEEP    = 2'd3;

  typedef enum logic [1:0] {
    WF_SINE   = 2'd0,
    WF_SQUARE = 2'd1,
    WF_SAW    = 2'd2,
    WF_NOISE  = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t             wave;
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
    logic [VOL_W-1:0]  decay;
    logic [15:0]       slide;
  } preset_t;

  function automatic preset_t preset_lookup(input logic [1:0] p);
    preset_t r;
    unique case (p)
      PRESET_SHOOT:   r = '{WF_SAW,   22'd204800, 16'd58982, 16'd65438, 16'hFC80};
      PRESET_EXPLODE: r = '{WF_NOISE, 22'd51200,  16'd58982, 16'd65503, 16'hFF80};
      PRESET_DASH:    r = '{WF_SINE,  22'd153600, 16'd26214, 16'd65470, 16'h0180};
      default:        r = '{WF_SINE,  22'd112640, 16'd32768, 16'd65470, 16'h0000};
    endcase
    return r;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic clear_mix;   // start of tick
    logic rd;          // read voice at rd_idx
    logic proc;        // stage 1: wave value + multiplies for read voice
    logic acc;         // stage 2: accumulate + write back
    logic load;        // load preset into load_idx
  } dp_cmd_t;

endpackage

>>> hdl/pdss_if.sv
// ----------------------------------------------------------------------------
// pdss_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface pdss_if #(parameter int unsigned WIDTH = 1);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pdss_sine_rom.sv
// ----------------------------------------------------------------------------
// pdss_sine_rom
// quarter-wave sine table, registered read
// ----------------------------------------------------------------------------
module pdss_sine_rom #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [15:0]              data
);
  localparam int unsigned AW = $clog2(DEPTH);

  function automatic logic [15:0] entry(input int unsigned k);
    longint unsigned x, x2, t, s, y;
    x  = ((longint'(k) * 2 + 1) << 16) / (2 * DEPTH);
    x2 = (x * x) >> 16;
    t  = 64'd42334 - ((x2 * 64'd4926) >> 16);
    s  = 64'd102944 - ((x2 * t) >> 16);
    y  = ((x * s) >> 16) >> 1;
    if (y > 64'd32767) y = 64'd32767;
    return y[15:0];
  endfunction

  logic [15:0] rom [DEPTH];
  always_comb begin
    for (int i = 0; i < DEPTH; i++) rom[i] = entry(i);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr[AW-1:0]];
  end
endmodule

>>> hdl/pdss_datapath.sv
// ----------------------------------------------------------------------------
// pdss_datapath
// voice memories, waveform, mixer and voice update
// ----------------------------------------------------------------------------
module pdss_datapath #(
  parameter int unsigned VOICE_COUNT      = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pdss_pkg::dp_cmd_t                   cmd,
  input  logic [$clog2(VOICE_COUNT+1)-1:0]    rd_idx,
  input  logic [$clog2(VOICE_COUNT+1)-1:0]    load_idx,
  input  logic [1:0]                          preset,
  input  logic [pdss_pkg::SCALE_W-1:0]        phase_scale,
  output logic [VOICE_COUNT-1:0]              active,
  output logic signed [15:0]                  mix_out
);
  localparam int unsigned IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PW = pdss_pkg::PHASE_W;
  localparam int unsigned FW = pdss_pkg::FREQ_W;

  // voice memories (reset state is zero only through active bits)
  logic [1:0]    mem_wave   [VOICE_COUNT];
  logic [PW-1:0] mem_phase  [VOICE_COUNT];
  logic [FW-1:0] mem_freq   [VOICE_COUNT];
  logic [15:0]   mem_vol    [VOICE_COUNT];
  logic [15:0]   mem_decay  [VOICE_COUNT];
  logic [15:0]   mem_slide  [VOICE_COUNT];

  pdss_pkg::preset_t pre;
  assign pre = pdss_pkg::preset_lookup(preset);

  // read stage registers
  logic [IW-1:0] r_idx;
  logic [1:0]    r_wave;
  logic [PW-1:0] r_phase;
  logic [FW-1:0] r_freq;
  logic [15:0]   r_vol, r_decay, r_slide;

  // sine address from phase of read voice
  logic [1:0]    quad;
  logic [AW-1:0] k, sine_addr;
  logic [15:0]   sine_mag;
  assign quad = r_phase[PW-1:PW-2];
  assign k    = r_phase[PW-3 -: AW];
  assign sine_addr = quad[0] ? ~k : k;

  pdss_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk(clk), .addr(sine_addr), .data(sine_mag));

  // stage1: rom read, lfsr step, multiplies
  logic [15:0] lfsr, lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ pdss_pkg::LFSR_TAPS) : (lfsr >> 1);

  logic signed [16:0] wave_v;
  logic [1:0]    s_wave;
  logic          s_neg;
  logic [15:0]   s_noise;
  logic [IW-1:0] s_idx;
  logic [PW-1:0] s_phase;
  logic [FW-1:0] s_freq_new;
  logic [15:0]   s_vol, s_vol_new;
  logic          s_phase_old_hi;
  logic [15:0]   s_saw;
  logic [39:0]   step_prod;
  logic [31:0]   vol_prod;
  logic signed [FW+1:0] f_sum;
  logic [FW-1:0] f_clamped;

  assign vol_prod = r_vol * r_decay;
  assign step_prod = r_freq * phase_scale;
  assign f_sum = $signed({2'b00, r_freq}) + (FW+2)'($signed(r_slide));

  always_comb begin
    if (f_sum < $signed({2'b00, pdss_pkg::FREQ_FLOOR})) f_clamped = pdss_pkg::FREQ_FLOOR;
    else if (f_sum[FW+1:FW] != 2'b00) f_clamped = '1;
    else f_clamped = f_sum[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.proc) begin
      s_wave     <= r_wave;
      s_neg      <= quad[1];
      s_noise    <= lfsr_step;
      s_idx      <= r_idx;
      s_phase    <= r_phase + step_prod[16 +: PW];
      s_vol      <= r_vol;
      s_vol_new  <= vol_prod[31:16];
      s_freq_new <= f_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.proc) begin
      s_phase_old_hi <= r_phase[PW-1];
      s_saw          <= r_phase[PW-1:8];
    end
  end

  always_comb begin
    case (s_wave)
      pdss_pkg::WF_SINE:   wave_v = s_neg ? -$signed({1'b0, sine_mag})
                                          : $signed({1'b0, sine_mag});
      pdss_pkg::WF_SQUARE: wave_v = s_phase_old_hi ? -17'sd32768 : 17'sd32768;
      pdss_pkg::WF_SAW:    wave_v = $signed({1'b0, s_saw}) - 17'sd32768;
      default:             wave_v = $signed({1'b0, s_noise}) - 17'sd32768;
    endcase
  end

  // stage2: term = floor(wave*vol / 65536) via arithmetic shift, accumulate
  logic signed [33:0] term_prod;
  logic signed [22:0] mix;
  assign term_prod = wave_v * $signed({1'b0, s_vol});

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr   <= pdss_pkg::LFSR_SEED;
      active <= '0;
      mix    <= '0;
    end else begin
      if (cmd.clear_mix) mix <= '0;
      if (cmd.proc && r_wave == pdss_pkg::WF_NOISE) lfsr <= lfsr_step;
      if (cmd.acc) begin
        mix <= mix + 23'(term_prod >>> 16);
        if (s_vol_new < pdss_pkg::VOL_FLOOR) active[s_idx] <= 1'b0;
      end
      if (cmd.load) active[load_idx[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      r_idx   <= rd_idx[IW-1:0];
      r_wave  <= mem_wave[rd_idx[IW-1:0]];
      r_phase <= mem_phase[rd_idx[IW-1:0]];
      r_freq  <= mem_freq[rd_idx[IW-1:0]];
      r_vol   <= mem_vol[rd_idx[IW-1:0]];
      r_decay <= mem_decay[rd_idx[IW-1:0]];
      r_slide <= mem_slide[rd_idx[IW-1:0]];
    end
    if (cmd.acc) begin
      mem_phase[s_idx] <= s_phase;
      mem_vol[s_idx]   <= s_vol_new;
      mem_freq[s_idx]  <= s_freq_new;
    end else if (cmd.load) begin
      mem_wave[load_idx[IW-1:0]]  <= pre.wave;
      mem_phase[load_idx[IW-1:0]] <= '0;
      mem_freq[load_idx[IW-1:0]]  <= pre.freq;
      mem_vol[load_idx[IW-1:0]]   <= pre.vol;
      mem_decay[load_idx[IW-1:0]] <= pre.decay;
      mem_slide[load_idx[IW-1:0]] <= pre.slide;
    end
  end

  always_comb begin
    if (mix > 23'sd32767) mix_out = 16'sh7FFF;
    else if (mix < -23'sd32768) mix_out = 16'sh8000;
    else mix_out = mix[15:0];
  end

  logic unused_cw;
  assign unused_cw = ^{rd_idx, load_idx, step_prod[15:0], vol_prod[15:0]};
endmodule

>>> hdl/pdss_ctrl.sv
// ----------------------------------------------------------------------------
// pdss_ctrl
// sequencer: free-voice search, per-voice tick walk, output register
// ----------------------------------------------------------------------------
module pdss_ctrl #(
  parameter int unsigned VOICE_COUNT = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [1:0]                       preset_in,
  output logic [1:0]                       preset,
  input  logic [VOICE_COUNT-1:0]           active,
  input  logic signed [15:0]               mix_out,
  output pdss_pkg::dp_cmd_t                cmd,
  output logic [$clog2(VOICE_COUNT+1)-1:0] rd_idx,
  output logic [$clog2(VOICE_COUNT+1)-1:0] load_idx,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               sample,
  output logic                             granted,
  output logic [4:0]                       voice_index
);
  localparam int unsigned CW = $clog2(VOICE_COUNT+1);
  localparam int unsigned IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_WALK, S_DRAIN1, S_DRAIN2, S_DONE} state_t;
  state_t state;

  logic [CW-1:0] idx;
  logic          p1, p2;   // pipeline occupancy: proc and acc slots

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign rd_idx   = idx;
  assign load_idx = idx;

  logic walk_rd;
  assign walk_rd = (state == S_WALK) && active[idx[IW-1:0]];

  always_comb begin
    cmd = '0;
    cmd.clear_mix = in_valid && in_ready && (command == pdss_pkg::COMMAND_TICK);
    cmd.rd   = walk_rd;
    cmd.proc = p1;
    cmd.acc  = p2;
    cmd.load = (state == S_FIND) && !active[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; p1 <= 1'b0; p2 <= 1'b0;
      out_valid <= 1'b0; sample <= '0; granted <= 1'b0; voice_index <= '0;
      preset <= '0;
    end else begin
      p1 <= walk_rd;
      p2 <= p1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_valid && in_ready) begin
            preset <= preset_in;
            state <= (command == pdss_pkg::COMMAND_TICK) ? S_WALK : S_FIND;
          end
        end
        S_FIND: begin
          if (!active[idx[IW-1:0]]) begin
            out_valid <= 1'b1; sample <= '0; granted <= 1'b1;
            voice_index <= 5'(idx);
            state <= S_IDLE;
          end else if (idx == CW'(VOICE_COUNT-1)) begin
            out_valid <= 1'b1; sample <= '0; granted <= 1'b0; voice_index <= '0;
            state <= S_IDLE;
          end else idx <= idx + 1'b1;
        end
        S_WALK: begin
          if (idx == CW'(VOICE_COUNT-1)) state <= S_DRAIN1;
          idx <= idx + 1'b1;
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1; sample <= mix_out; granted <= 1'b0; voice_index <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_grant_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_IDLE)) else $error("load not followed by idle");
  a_acc_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> $past(cmd.proc)) else $error("accumulate without process");
`endif
endmodule

>>> hdl/polyphonic_decay_slide_synth_top.sv
// ----------------------------------------------------------------------------
// polyphonic_decay_slide_synth_top
// polyphonic decaying, sliding oscillator mixer
// ----------------------------------------------------------------------------
// One transaction in, one out. A trigger searches voices from 0 upward, one
// voice per cycle. A tick walks all voices one per cycle through a read,
// wave/multiply and accumulate pipeline (voice memory read port sets the
// pace). The result register holds until taken; the next transaction is
// accepted once it is gone. phase_scale is to be written only when idle;
// the block itself does not enforce it.
module polyphonic_decay_slide_synth_top #(
  parameter int unsigned VOICE_COUNT      = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  pdss_if.sink                          in_ch,   // data: {preset, command}
  pdss_if.source                        out_ch,  // data: {voice_index, granted, sample}
  input  logic                          cfg_we,
  input  logic [pdss_pkg::SCALE_W-1:0]  cfg_wdata
);
  localparam int unsigned CW = $clog2(VOICE_COUNT+1);

  // configuration register
  logic [pdss_pkg::SCALE_W-1:0] phase_scale;
  always_ff @(posedge clk) begin
    if (rst) phase_scale <= pdss_pkg::SCALE_RESET;
    else if (cfg_we) phase_scale <= cfg_wdata;
  end

  pdss_pkg::dp_cmd_t       cmd;
  logic [CW-1:0]           rd_idx, load_idx;
  logic [VOICE_COUNT-1:0]  active;
  logic signed [15:0]      mix_out, sample;
  logic                    granted;
  logic [4:0]              voice_index;
  logic [1:0]              preset;

  pdss_ctrl #(.VOICE_COUNT(VOICE_COUNT)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .command(in_ch.data[0]), .preset_in(in_ch.data[2:1]), .preset(preset),
    .active(active), .mix_out(mix_out), .cmd(cmd),
    .rd_idx(rd_idx), .load_idx(load_idx),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sample(sample), .granted(granted), .voice_index(voice_index));

  pdss_datapath #(.VOICE_COUNT(VOICE_COUNT), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rd_idx(rd_idx), .load_idx(load_idx),
    .preset(preset), .phase_scale(phase_scale), .active(active), .mix_out(mix_out));

  // result payload
  assign out_ch.data = {voice_index, granted, sample};
endmodule
